// File: rtl/http_request_line_parser_core_defines.svh
// assertion macros shared by the request line parser rtl
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HRLP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrlp same-cycle check failed");
`define HRLP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrlp next-cycle check failed");
`else
`define HRLP_ASSERT_IMP(name, ante, cons)
`define HRLP_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: rtl/hrlp_pkg.sv
// types, codes and name tables of the request line parser
`default_nettype none
package hrlp_pkg;

  localparam int NMETH = 8;
  localparam int NVER  = 5;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic KIND_URI     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [3:0] METHOD_UNDEF   = 4'd0;
  localparam logic [3:0] METHOD_UNKNOWN = 4'd9;
  localparam logic [2:0] VER_UNDEF      = 3'd0;
  localparam logic [2:0] VER_UNKNOWN    = 3'd6;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_METHOD  = 2'd1;
  localparam logic [1:0] STAT_NO_URI     = 2'd2;
  localparam logic [1:0] STAT_NO_VERSION = 2'd3;

  localparam logic [3:0] POS_MAX = 4'd15;

  typedef enum logic [6:0] {
    PH_SKIP_METH = 7'b0000001,
    PH_METH      = 7'b0000010,
    PH_SKIP_URI  = 7'b0000100,
    PH_URI       = 7'b0001000,
    PH_SKIP_VER  = 7'b0010000,
    PH_VER       = 7'b0100000,
    PH_DONE      = 7'b1000000
  } hrlp_phase_t;

  // one queue entry: optional uri byte and optional end summary
  typedef struct packed {
    logic       uri_vld;
    logic [7:0] uri_char;
    logic       sum_vld;
    logic [3:0] method;
    logic [2:0] version;
    logic [1:0] status;
    logic [7:0] count;
  } hrlp_entry_t;

  // names left aligned, byte p at [63-8p -: 8]
  function automatic logic [63:0] meth_str(input logic [2:0] idx);
    logic [63:0] s;
    s = '0;
    case (idx)
      3'd0:    s = {"GET", 40'h0};
      3'd1:    s = {"HEAD", 32'h0};
      3'd2:    s = {"POST", 32'h0};
      3'd3:    s = {"PUT", 40'h0};
      3'd4:    s = {"DELETE", 16'h0};
      3'd5:    s = {"CONNECT", 8'h0};
      3'd6:    s = {"OPTIONS", 8'h0};
      3'd7:    s = {"TRACE", 24'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] meth_len(input logic [2:0] idx);
    logic [3:0] n;
    n = 4'd0;
    case (idx)
      3'd0:    n = 4'd3;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd3;
      3'd4:    n = 4'd6;
      3'd5:    n = 4'd7;
      3'd6:    n = 4'd7;
      3'd7:    n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] ver_str(input logic [2:0] idx);
    logic [63:0] s;
    s = '0;
    case (idx)
      3'd0:    s = "HTTP/0.9";
      3'd1:    s = "HTTP/1.0";
      3'd2:    s = "HTTP/1.1";
      3'd3:    s = {"HTTP/2", 16'h0};
      3'd4:    s = {"HTTP/3", 16'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] ver_len(input logic [2:0] idx);
    logic [3:0] n;
    n = 4'd0;
    case (idx)
      3'd0, 3'd1, 3'd2: n = 4'd8;
      3'd3, 3'd4:       n = 4'd6;
      default:          n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] str_byte(input logic [63:0] s, input logic [2:0] pos);
    return s[63 - 8*pos -: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/hrlp_front.sv
// front end: accepts bytes, tracks tokens and classifies method and version
`default_nettype none
module hrlp_front #(
  parameter int URI_MAX = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_char_in,
  input  wire logic              in_end_of_line,
  output logic                   in_stall,
  input  wire logic              q_full,
  output logic                   push,
  output hrlp_pkg::hrlp_entry_t  push_entry
);

  localparam int CW = (URI_MAX > 2) ? $clog2(URI_MAX) : 1;
  localparam int EW = CW + 8;

  hrlp_pkg::hrlp_phase_t phase_r, phase_nxt;
  logic [hrlp_pkg::NMETH-1:0] mmask_r, mmask_nxt, mmask_step;
  logic [hrlp_pkg::NVER-1:0]  vmask_r, vmask_nxt, vmask_step;
  logic [3:0]    mpos_r, mpos_nxt;
  logic [3:0]    vpos_r, vpos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ended_r, ended_nxt;

  logic          accept;
  logic          active, sp, crlf, emit, emit_ok;
  logic [EW-1:0] cnt_ext, cnt_nxt_ext;
  logic [3:0]    mcls;
  logic [2:0]    vcls;
  logic          mfound, vfound;

  assign in_stall = !rst_n || q_full;
  assign accept   = in_valid && !in_stall;

  assign active = !ended_r && (in_char_in != hrlp_pkg::CH_NUL);
  assign sp     = (in_char_in == hrlp_pkg::CH_SP);
  assign crlf   = (in_char_in == hrlp_pkg::CH_CR) || (in_char_in == hrlp_pkg::CH_LF);
  assign cnt_ext = {8'd0, cnt_r};

  // per-name match against the byte at the current position
  always_comb begin
    for (int i = 0; i < hrlp_pkg::NMETH; i++) begin
      mmask_step[i] = mmask_r[i] && (mpos_r < hrlp_pkg::meth_len(3'(i))) &&
        (hrlp_pkg::str_byte(hrlp_pkg::meth_str(3'(i)), mpos_r[2:0]) == in_char_in);
    end
    for (int i = 0; i < hrlp_pkg::NVER; i++) begin
      vmask_step[i] = vmask_r[i] && (vpos_r < hrlp_pkg::ver_len(3'(i))) &&
        (hrlp_pkg::str_byte(hrlp_pkg::ver_str(3'(i)), vpos_r[2:0]) == in_char_in);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    mmask_nxt = mmask_r;
    vmask_nxt = vmask_r;
    mpos_nxt  = mpos_r;
    vpos_nxt  = vpos_r;
    ended_nxt = ended_r;
    emit      = 1'b0;
    if (!ended_r && (in_char_in == hrlp_pkg::CH_NUL)) begin
      ended_nxt = 1'b1;
    end
    if (active) begin
      case (phase_r)
        hrlp_pkg::PH_SKIP_METH, hrlp_pkg::PH_METH: begin
          if (sp) begin
            if (phase_r == hrlp_pkg::PH_METH) phase_nxt = hrlp_pkg::PH_SKIP_URI;
          end else begin
            phase_nxt = hrlp_pkg::PH_METH;
            mmask_nxt = mmask_step;
            if (mpos_r != hrlp_pkg::POS_MAX) mpos_nxt = mpos_r + 4'd1;
          end
        end
        hrlp_pkg::PH_SKIP_URI, hrlp_pkg::PH_URI: begin
          if (sp) begin
            if (phase_r == hrlp_pkg::PH_URI) phase_nxt = hrlp_pkg::PH_SKIP_VER;
          end else begin
            phase_nxt = hrlp_pkg::PH_URI;
            emit      = 1'b1;
          end
        end
        hrlp_pkg::PH_SKIP_VER, hrlp_pkg::PH_VER: begin
          if (crlf) begin
            if (phase_r == hrlp_pkg::PH_VER) phase_nxt = hrlp_pkg::PH_DONE;
          end else begin
            phase_nxt = hrlp_pkg::PH_VER;
            vmask_nxt = vmask_step;
            if (vpos_r != hrlp_pkg::POS_MAX) vpos_nxt = vpos_r + 4'd1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign emit_ok     = emit && (cnt_ext < EW'(URI_MAX - 1));
  assign cnt_nxt     = emit_ok ? cnt_r + CW'(1) : cnt_r;
  assign cnt_nxt_ext = {8'd0, cnt_nxt};

  // classification uses the state after this byte
  always_comb begin
    mcls   = hrlp_pkg::METHOD_UNKNOWN;
    mfound = 1'b0;
    for (int i = 0; i < hrlp_pkg::NMETH; i++) begin
      if (!mfound && mmask_nxt[i] && (mpos_nxt == hrlp_pkg::meth_len(3'(i)))) begin
        mfound = 1'b1;
        mcls   = 4'(i + 1);
      end
    end
    vcls   = hrlp_pkg::VER_UNKNOWN;
    vfound = 1'b0;
    for (int i = 0; i < hrlp_pkg::NVER; i++) begin
      if (!vfound && vmask_nxt[i] && (vpos_nxt == hrlp_pkg::ver_len(3'(i)))) begin
        vfound = 1'b1;
        vcls   = 3'(i + 1);
      end
    end
  end

  always_comb begin
    push_entry          = '0;
    push_entry.uri_vld  = emit_ok;
    push_entry.uri_char = in_char_in;
    push_entry.sum_vld  = in_end_of_line;
    push_entry.count    = (cnt_nxt_ext > EW'(255)) ? 8'hFF : cnt_nxt_ext[7:0];
    push_entry.method   = mcls;
    push_entry.version  = hrlp_pkg::VER_UNDEF;
    case (phase_nxt)
      hrlp_pkg::PH_SKIP_METH: begin
        push_entry.method = hrlp_pkg::METHOD_UNDEF;
        push_entry.status = hrlp_pkg::STAT_NO_METHOD;
      end
      hrlp_pkg::PH_METH, hrlp_pkg::PH_SKIP_URI: begin
        push_entry.status = hrlp_pkg::STAT_NO_URI;
      end
      hrlp_pkg::PH_URI, hrlp_pkg::PH_SKIP_VER: begin
        push_entry.status = hrlp_pkg::STAT_NO_VERSION;
      end
      default: begin
        push_entry.version = vcls;
        push_entry.status  = hrlp_pkg::STAT_OK;
      end
    endcase
  end

  assign push = accept && (emit_ok || in_end_of_line);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end_of_line)) begin
      phase_r <= hrlp_pkg::PH_SKIP_METH;
      mmask_r <= '1;
      vmask_r <= '1;
      mpos_r  <= '0;
      vpos_r  <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mmask_r <= mmask_nxt;
      vmask_r <= vmask_nxt;
      mpos_r  <= mpos_nxt;
      vpos_r  <= vpos_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/hrlp_queue.sv
// short queue between the front end and the result stage
`default_nettype none
`include "http_request_line_parser_core_defines.svh"
module hrlp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire hrlp_pkg::hrlp_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_vld,
  output hrlp_pkg::hrlp_entry_t      head
);

  hrlp_pkg::hrlp_entry_t mem_r [hrlp_pkg::QDEPTH];
  logic [hrlp_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [hrlp_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (hrlp_pkg::QAW+1)'(hrlp_pkg::QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `HRLP_ASSERT_IMP(a_pop_nonempty, pop, head_vld)
  `HRLP_ASSERT_NXT(a_cnt_grows, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

// File: rtl/hrlp_back.sv
// result stage: turns queue entries into one or two output transactions
`default_nettype none
`include "http_request_line_parser_core_defines.svh"
module hrlp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_vld,
  input  wire hrlp_pkg::hrlp_entry_t head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_kind,
  output logic [7:0]                 out_uri_char,
  output logic [3:0]                 out_method_code,
  output logic [2:0]                 out_version_code,
  output logic [1:0]                 out_parse_status,
  output logic [7:0]                 out_uri_count,
  output logic                       out_last_of_run
);

  logic       valid_r, valid_nxt;
  logic       uri_done_r, uri_done_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] char_r, char_nxt;
  logic [3:0] meth_r, meth_nxt;
  logic [2:0] ver_r, ver_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic       slot_free, load, take_uri;

  assign slot_free = !valid_r || !out_stall;
  assign load      = slot_free && head_vld;
  assign take_uri  = head.uri_vld && !uri_done_r;
  // an entry with both results stays in the queue until its summary is loaded
  assign pop       = load && !(take_uri && head.sum_vld);

  always_comb begin
    valid_nxt    = slot_free ? head_vld : valid_r;
    uri_done_nxt = load ? (take_uri && head.sum_vld) : uri_done_r;
    kind_nxt     = kind_r;
    char_nxt     = char_r;
    meth_nxt     = meth_r;
    ver_nxt      = ver_r;
    stat_nxt     = stat_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    if (load) begin
      if (take_uri) begin
        kind_nxt = hrlp_pkg::KIND_URI;
        char_nxt = head.uri_char;
        meth_nxt = hrlp_pkg::METHOD_UNDEF;
        ver_nxt  = hrlp_pkg::VER_UNDEF;
        stat_nxt = hrlp_pkg::STAT_OK;
        cnt_nxt  = 8'd0;
        last_nxt = !head.sum_vld;
      end else begin
        kind_nxt = hrlp_pkg::KIND_SUMMARY;
        char_nxt = 8'd0;
        meth_nxt = head.method;
        ver_nxt  = head.version;
        stat_nxt = head.status;
        cnt_nxt  = head.count;
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      uri_done_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      uri_done_r <= uri_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    char_r <= char_nxt;
    meth_r <= meth_nxt;
    ver_r  <= ver_nxt;
    stat_r <= stat_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_uri_char     = char_r;
  assign out_method_code  = meth_r;
  assign out_version_code = ver_r;
  assign out_parse_status = stat_r;
  assign out_uri_count    = cnt_r;
  assign out_last_of_run  = last_r;

  `HRLP_ASSERT_IMP(a_split_has_summary, uri_done_r, head_vld && head.sum_vld)
  `HRLP_ASSERT_NXT(a_split_marked, load && take_uri && head.sum_vld, uri_done_r)

endmodule
`default_nettype wire

// File: rtl/http_request_line_parser_core.sv
// HTTP request line parser: byte stream in, URI bytes and line summary out
//
// Input channel: one byte per transaction (in_char_in) with in_end_of_line on
// the last byte of a line. The method and version tokens are matched on the
// fly; URI bytes are forwarded as kind 0 results, up to URI_MAX-1 per line.
// The last byte of a line also yields a kind 1 summary with method, version,
// URI byte count and parse status; the parser then restarts for a new line.
// Each result passes through the queue and then the output register to out_*.
// Throughput: one byte per cycle while in_stall is low; a final byte that also
// carries a URI byte produces two results, one after the other on out_*.
// A four-entry queue separates the byte front end from the output stage, so
// bytes keep flowing while out_stall holds a result; out of reset, in_stall
// rises only when that queue is full. The held output transaction does not
// change under stall. Reset (rst_n low, synchronous) empties the queue, drops
// out_valid, returns the parser to the start of a line and holds in_stall high.
`default_nettype none
module http_request_line_parser_core #(
  parameter int URI_MAX = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_line,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_uri_char,
  output logic [3:0]      out_method_code,
  output logic [2:0]      out_version_code,
  output logic [1:0]      out_parse_status,
  output logic [7:0]      out_uri_count,
  output logic            out_last_of_run
);

  logic                  q_full, q_push, q_pop, q_head_vld;
  hrlp_pkg::hrlp_entry_t q_push_entry, q_head;

  hrlp_front #(
    .URI_MAX(URI_MAX)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_char_in     (in_char_in),
    .in_end_of_line (in_end_of_line),
    .in_stall       (in_stall),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (q_push_entry)
  );

  hrlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_vld   (q_head_vld),
    .head       (q_head)
  );

  hrlp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_vld         (q_head_vld),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_uri_char     (out_uri_char),
    .out_method_code  (out_method_code),
    .out_version_code (out_version_code),
    .out_parse_status (out_parse_status),
    .out_uri_count    (out_uri_count),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

// File: tb/sv/request_line_checker.sv
// request line parser checker: tracks each line's bytes, predicts results and compares them
module request_line_checker #(
  parameter int URI_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_line,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_uri_char,
  input  logic [3:0] out_method_code,
  input  logic [2:0] out_version_code,
  input  logic [1:0] out_parse_status,
  input  logic [7:0] out_uri_count,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending_results
);
  import hrlp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] uri_char;
    logic [3:0] method;
    logic [2:0] version;
    logic [1:0] status;
    logic [7:0] count;
    logic       last;
  } line_result_t;

  string method_names [NMETH] = '{"GET", "HEAD", "POST", "PUT",
                                  "DELETE", "CONNECT", "OPTIONS", "TRACE"};
  string version_names [NVER] = '{"HTTP/0.9", "HTTP/1.0", "HTTP/1.1",
                                  "HTTP/2", "HTTP/3"};

  line_result_t line_results_due[$];

  hrlp_phase_t phase;
  logic [7:0]  meth_mask;
  logic [3:0]  meth_pos;
  logic [4:0]  ver_mask;
  logic [3:0]  ver_pos;
  int          uri_kept;
  logic        str_ended;

  function automatic void restart_line();
    phase     = PH_SKIP_METH;
    meth_mask = '1;
    meth_pos  = '0;
    ver_mask  = '1;
    ver_pos   = '0;
    uri_kept  = 0;
    str_ended = 1'b0;
  endfunction

  // drop every method whose name does not have byte c at position pos
  function automatic logic [7:0] narrow_methods(input logic [7:0] mask,
                                                input logic [3:0] pos,
                                                input logic [7:0] c);
    logic [7:0] m;
    m = mask;
    for (int i = 0; i < NMETH; i++) begin
      if (pos >= method_names[i].len() || 8'(method_names[i][pos]) != c) m[i] = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [4:0] narrow_versions(input logic [4:0] mask,
                                                 input logic [3:0] pos,
                                                 input logic [7:0] c);
    logic [4:0] m;
    m = mask;
    for (int i = 0; i < NVER; i++) begin
      if (pos >= version_names[i].len() || 8'(version_names[i][pos]) != c) m[i] = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [3:0] method_of_line();
    for (int i = 0; i < NMETH; i++) begin
      if (meth_mask[i] && meth_pos == method_names[i].len()) return 4'(i + 1);
    end
    return METHOD_UNKNOWN;
  endfunction

  function automatic logic [2:0] version_of_line();
    for (int i = 0; i < NVER; i++) begin
      if (ver_mask[i] && ver_pos == version_names[i].len()) return 3'(i + 1);
    end
    return VER_UNKNOWN;
  endfunction

  // advance the tokenizer by one byte and queue the uri byte and summary it yields
  function automatic void follow_request_byte(input logic [7:0] c, input logic eol);
    line_result_t r;
    logic         emit;
    logic         sp;
    logic         crlf;
    emit = 1'b0;
    if (!str_ended) begin
      if (c == CH_NUL) begin
        str_ended = 1'b1;
      end else begin
        sp   = (c == CH_SP);
        crlf = (c == CH_CR) || (c == CH_LF);
        case (phase)
          PH_SKIP_METH, PH_METH: begin
            if (sp) begin
              if (phase == PH_METH) phase = PH_SKIP_URI;
            end else begin
              phase     = PH_METH;
              meth_mask = narrow_methods(meth_mask, meth_pos, c);
              if (meth_pos != POS_MAX) meth_pos++;
            end
          end
          PH_SKIP_URI, PH_URI: begin
            if (sp) begin
              if (phase == PH_URI) phase = PH_SKIP_VER;
            end else begin
              phase = PH_URI;
              emit  = 1'b1;
            end
          end
          PH_SKIP_VER, PH_VER: begin
            if (crlf) begin
              if (phase == PH_VER) phase = PH_DONE;
            end else begin
              phase    = PH_VER;
              ver_mask = narrow_versions(ver_mask, ver_pos, c);
              if (ver_pos != POS_MAX) ver_pos++;
            end
          end
          default: ;
        endcase
        if (emit && uri_kept < URI_MAX - 1) begin
          uri_kept++;
          r          = '0;
          r.kind     = KIND_URI;
          r.uri_char = c;
          r.last     = !eol;
          line_results_due.push_back(r);
        end
      end
    end
    if (eol) begin
      r       = '0;
      r.kind  = KIND_SUMMARY;
      r.last  = 1'b1;
      r.count = (uri_kept > 255) ? 8'd255 : 8'(uri_kept);
      case (phase)
        PH_SKIP_METH: r.status = STAT_NO_METHOD;
        PH_METH, PH_SKIP_URI: begin
          r.method = method_of_line();
          r.status = STAT_NO_URI;
        end
        PH_URI, PH_SKIP_VER: begin
          r.method = method_of_line();
          r.status = STAT_NO_VERSION;
        end
        default: begin
          r.method  = method_of_line();
          r.version = version_of_line();
          r.status  = STAT_OK;
        end
      endcase
      line_results_due.push_back(r);
      restart_line();
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    line_result_t due;
    if (!rst_n) begin
      restart_line();
      line_results_due.delete();
    end else begin
      // compare before predicting: a result never leaves in its byte's own cycle
      if (out_valid && !out_stall) begin
        if (line_results_due.size() == 0) begin
          $error("unexpected result transaction: kind %0d uri_char %0h", out_kind,
                 out_uri_char);
          fail_count++;
        end else begin
          due = line_results_due.pop_front();
          check_field("out_kind", 8'(due.kind), 8'(out_kind));
          check_field("out_uri_char", due.uri_char, out_uri_char);
          check_field("out_method_code", 8'(due.method), 8'(out_method_code));
          check_field("out_version_code", 8'(due.version), 8'(out_version_code));
          check_field("out_parse_status", 8'(due.status), 8'(out_parse_status));
          check_field("out_uri_count", due.count, out_uri_count);
          check_field("out_last_of_run", 8'(due.last), 8'(out_last_of_run));
        end
      end
      if (in_valid && !in_stall) follow_request_byte(in_char_in, in_end_of_line);
    end
    pending_results = line_results_due.size();
  end

endmodule

// File: tb/sv/http_request_line_parser_core_tb.sv
// testbench top of the request line parser: byte stimulus, output stalls and verdict
module http_request_line_parser_core_tb;
  import hrlp_pkg::*;

  localparam int URI_MAX = 256;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_end_of_line;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_uri_char;
  logic [3:0] out_method_code;
  logic [2:0] out_version_code;
  logic [1:0] out_parse_status;
  logic [7:0] out_uri_count;
  logic       out_last_of_run;
  int         fail_count;
  int         pending_results;

  string method_names [NMETH] = '{"GET", "HEAD", "POST", "PUT",
                                  "DELETE", "CONNECT", "OPTIONS", "TRACE"};
  string version_names [NVER] = '{"HTTP/0.9", "HTTP/1.0", "HTTP/1.1",
                                  "HTTP/2", "HTTP/3"};

  logic [7:0] line_bytes[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         hold_requests = 0;
  int         holds_served = 0;

  http_request_line_parser_core #(
    .URI_MAX(URI_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_uri_char     (out_uri_char),
    .out_method_code  (out_method_code),
    .out_version_code (out_version_code),
    .out_parse_status (out_parse_status),
    .out_uri_count    (out_uri_count),
    .out_last_of_run  (out_last_of_run)
  );

  request_line_checker #(
    .URI_MAX(URI_MAX)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_uri_char     (out_uri_char),
    .out_method_code  (out_method_code),
    .out_version_code (out_version_code),
    .out_parse_status (out_parse_status),
    .out_uri_count    (out_uri_count),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one byte transaction, preceded by an idle gap when the current burst is used up
  task automatic send_byte(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_char_in     <= c;
    in_end_of_line <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++) begin
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    end
    line_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
  endtask

  // printable bytes, or any byte but space and zero
  task automatic add_word(input int n, input bit any_byte);
    logic [7:0] ch;
    repeat (n) begin
      if (any_byte) begin
        do begin
          ch = 8'($urandom_range(1, 255));
        end while (ch == CH_SP);
      end else begin
        ch = 8'($urandom_range(33, 126));
      end
      line_bytes.push_back(ch);
    end
  endtask

  task automatic build_random_line();
    int    shape;
    int    cut;
    string name;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      // raw noise
      repeat ($urandom_range(1, 24)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SP);
      name = method_names[$urandom_range(0, NMETH - 1)];
      case ($urandom_range(0, 11))
        8: add_word($urandom_range(1, 18), 1'b0);
        9: add_text(name.substr(0, $urandom_range(0, name.len() - 2)));
        10: begin
          add_text(name);
          add_word($urandom_range(1, 10), 1'b0);
        end
        default: add_text(name);
      endcase
      repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SP);
      add_word($urandom_range(1, 20), $urandom_range(0, 3) == 0);
      line_bytes.push_back(CH_SP);
      // a second space becomes part of the version token
      if ($urandom_range(0, 7) == 0) line_bytes.push_back(CH_SP);
      if ($urandom_range(0, 7) == 0) line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      name = version_names[$urandom_range(0, NVER - 1)];
      case ($urandom_range(0, 9))
        6: add_word($urandom_range(1, 18), 1'b0);
        7: add_text(name.substr(0, $urandom_range(0, name.len() - 2)));
        8: begin
          add_text(name);
          add_word($urandom_range(1, 4), 1'b0);
        end
        9: begin
          add_text(name);
          line_bytes.push_back(CH_SP);
          add_word($urandom_range(1, 4), 1'b0);
        end
        default: add_text(name);
      endcase
      case ($urandom_range(0, 4))
        0: begin
          line_bytes.push_back(CH_CR);
          line_bytes.push_back(CH_LF);
        end
        1: line_bytes.push_back(CH_LF);
        2: line_bytes.push_back(CH_CR);
        3: ;
        default: begin
          line_bytes.push_back(CH_CR);
          line_bytes.push_back(CH_LF);
          add_word($urandom_range(1, 8), 1'b1);
        end
      endcase
      if (shape == 2) begin
        cut = $urandom_range(1, line_bytes.size());
        while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
      if (shape == 3) line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CH_NUL);
    end
  endtask

  // receiver: rotates through four stall patterns, long hold-off on request
  initial begin : receiver
    int cyc;
    int hold_left;
    cyc       = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = 120;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((cyc / 256) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cyc[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    bit long_done;
    bit drain_done;
    long_done      = 1'b0;
    drain_done     = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_in     = 8'h00;
    in_end_of_line = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // a lone space: no method token
    line_bytes.push_back(CH_SP);
    send_line();
    // method only
    add_text("PUT");
    send_line();
    // line ends on a uri byte: uri byte and summary from one transaction
    add_text("GET /");
    send_line();
    // byte 0xff in the uri, version cut by cr
    add_text("X ");
    line_bytes.push_back(8'hFF);
    add_text(" HTTP/3");
    line_bytes.push_back(CH_CR);
    send_line();
    // zero byte ends the string, the rest is ignored
    add_text("G");
    line_bytes.push_back(CH_NUL);
    line_bytes.push_back(8'h80);
    send_line();

    while (bytes_sent < 1150) begin
      if (!long_done && bytes_sent > 300) begin
        // uri far beyond the kept length while the receiver holds off
        long_done = 1'b1;
        hold_requests++;
        burst_left = 400;
        add_text("POST ");
        add_word(300, 1'b0);
        line_bytes.push_back(CH_SP);
        add_text("HTTP/1.0");
        line_bytes.push_back(CH_LF);
      end else begin
        if (!drain_done && bytes_sent > 700) begin
          drain_done = 1'b1;
          in_valid <= 1'b0;
          @(negedge clk);
          wait (pending_results == 0);
          @(posedge clk);
          burst_left = 0;
        end
        build_random_line();
      end
      send_line();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_results == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_request_line_parser_core_tb OK");
    end else begin
      $display("http_request_line_parser_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("http_request_line_parser_core_tb NOT OK");
    $finish;
  end

endmodule

// File: http_request_line_parser_core.f
+incdir+rtl
rtl/hrlp_pkg.sv
rtl/hrlp_front.sv
rtl/hrlp_queue.sv
rtl/hrlp_back.sv
rtl/http_request_line_parser_core.sv
tb/sv/request_line_checker.sv
tb/sv/http_request_line_parser_core_tb.sv
